>>> design/rorq_pkg.sv
// shared types and constants of the in-order release reorder queue
// no dependencies; imported by the interfaces and every module
`default_nettype none

package rorq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_W    = 32;
   localparam int ID_W        = 32;

   // operation codes
   localparam logic [1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [1:0] OP_DISPATCH = 2'd1;
   localparam logic [1:0] OP_COMPLETE = 2'd2;
   localparam logic [1:0] OP_RETIRE   = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // contents of one queue cell
   typedef struct packed {
      logic                valid;
      logic                filled;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
   } cell_type;

   localparam cell_type EMPTY_CELL = '0;

   // per-cycle control of one chain of cells
   typedef struct packed {
      logic                push;
      logic                pop;
      logic                search;
      logic                data_filled;
      logic [ID_W-1:0]     data_id;
      logic [HANDLE_W-1:0] data_handle;
   } chain_ctl_type;

endpackage

`default_nettype wire

>>> design/rorq_if.sv
// request and response channel interfaces of the reorder queue
// depends on rorq_pkg
`default_nettype none

interface rorq_req_if
   import rorq_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [HANDLE_W-1:0] event_handle;
   logic [ID_W-1:0]     event_id;

   modport source (output valid, op, event_handle, event_id, input ready);
   modport sink   (input valid, op, event_handle, event_id, output ready);
endinterface

interface rorq_rsp_if
   import rorq_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic [HANDLE_W-1:0] handle_out;
   logic                incoming_nonempty;
   logic                outgoing_ready;

   modport source (output valid, status, handle_out, incoming_nonempty, outgoing_ready,
                   input ready);
   modport sink   (input valid, status, handle_out, incoming_nonempty, outgoing_ready,
                   output ready);
endinterface

`default_nettype wire

>>> design/rorq_cell.sv
// one queue cell: holds an entry, shifts toward the head on pop
// depends on rorq_pkg
`default_nettype none

module rorq_cell
   import rorq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire chain_ctl_type ctl,
   input  wire cell_type      upper,      // neighbor one place further from head
   input  wire logic          lower_valid,
   input  wire logic          hit_above,  // a younger cell already matched
   output logic               hit_below,
   output cell_type           state,
   output cell_type           state_nxt
);

   cell_type state_ff;
   cell_type state_in;
   logic     match;

   assign match     = ctl.search && state_ff.valid && (state_ff.id == ctl.data_id);
   assign hit_below = hit_above || match;

   always_comb begin
      state_in = state_ff;
      if (ctl.pop) begin
         state_in = upper;
      end else if (ctl.push && !state_ff.valid && lower_valid) begin
         state_in.valid  = 1'b1;
         state_in.filled = ctl.data_filled;
         state_in.id     = ctl.data_id;
         state_in.handle = ctl.data_handle;
      end else if (match && !hit_above) begin
         state_in.filled = 1'b1;
         state_in.handle = ctl.data_handle;
      end
   end

   always_ff @(posedge clock) begin
      state_ff.id     <= state_in.id;
      state_ff.handle <= state_in.handle;
      if (reset) begin
         state_ff.valid  <= 1'b0;
         state_ff.filled <= 1'b0;
      end else begin
         state_ff.valid  <= state_in.valid;
         state_ff.filled <= state_in.filled;
      end
   end

   assign state     = state_ff;
   assign state_nxt = state_in;

endmodule

`default_nettype wire

>>> design/rorq_chain.sv
// a row of queue cells with the head at cell 0
// depends on rorq_pkg and rorq_cell
`default_nettype none

module rorq_chain
   import rorq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire chain_ctl_type ctl,
   output cell_type           head,
   output cell_type           head_nxt,
   output logic               full,
   output logic               found
);

   cell_type               cells     [QUEUE_DEPTH];
   cell_type               cells_nxt [QUEUE_DEPTH];
   cell_type               uppers    [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0]   hits;
   logic [QUEUE_DEPTH-1:0] valid_vec;
   logic [QUEUE_DEPTH-1:0] lower_valid;
   logic [QUEUE_DEPTH-1:0] fill_vec;

   assign hits[QUEUE_DEPTH] = 1'b0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign uppers[i] = EMPTY_CELL;
      end else begin : g_mid
         assign uppers[i] = cells[i+1];
      end
      if (i == 0) begin : g_first
         assign lower_valid[i] = 1'b1;
      end else begin : g_rest
         assign lower_valid[i] = cells[i-1].valid;
      end

      rorq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .upper       (uppers[i]),
         .lower_valid (lower_valid[i]),
         .hit_above   (hits[i+1]),
         .hit_below   (hits[i]),
         .state       (cells[i]),
         .state_nxt   (cells_nxt[i])
      );

      assign valid_vec[i] = cells[i].valid;
      assign fill_vec[i]  = hits[i] && !hits[i+1];
   end

   assign head     = cells[0];
   assign head_nxt = cells_nxt[0];
   assign full     = valid_vec[QUEUE_DEPTH-1];
   assign found    = hits[0];

   // occupied cells always form an unbroken run from the head
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, valid_vec} + {{QUEUE_DEPTH{1'b0}}, 1'b1}))
      else $error("queue cells not contiguous from head");

   // a search fills at most one cell
   a_single_fill: assert property (@(posedge clock) disable iff (reset)
      $onehot0(fill_vec))
      else $error("search filled more than one cell");

   // a pop moves the second entry to the head
   a_pop_shift: assert property (@(posedge clock) disable iff (reset)
      ctl.pop && cells[1].valid |=> head == $past(cells[1]))
      else $error("pop did not shift second entry to head");

   // a push into a non-full chain grows it by one entry
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      ctl.push && !ctl.pop && !full
      |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
      else $error("push did not add one entry");

endmodule

`default_nettype wire

>>> design/in_order_release_reorder_queue.sv
// top level of the in-order release reorder queue
// depends on rorq_pkg, rorq_if and rorq_chain
`default_nettype none

// Two queues of QUEUE_DEPTH entries, each a chain of cells with the head at
// cell 0: an incoming FIFO of (handle, id) and an outgoing queue of slots.
// Every request transaction is one operation (enqueue, dispatch, complete,
// retire) and produces exactly one response transaction holding the status,
// the released handle and the queue flags after the operation. An operation
// finishes in the cycle it is accepted: the response is registered, so it
// appears in the next cycle, and the block sustains one transaction per cycle
// as long as the response side keeps up. Each cell compares its id with the
// completion id in parallel; the youngest match wins through a one-bit hit
// signal that ripples from the tail toward the head. Pops shift every cell
// one place toward the head in the same cycle. There is no clearing pass
// after reset. sort_mode is written through csr_wr_en / csr_wr_data and the
// write only takes effect while both queues are empty.

module in_order_release_reorder_queue
   import rorq_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rorq_req_if.sink    req_if,
   rorq_rsp_if.source  rsp_if,
   input  wire logic   csr_wr_en,
   input  wire logic   csr_wr_data
);

   // configuration
   logic sort_mode_ff;

   // queue chains
   chain_ctl_type in_ctl;
   chain_ctl_type out_ctl;
   cell_type      in_head;
   cell_type      in_head_nxt;
   cell_type      out_head;
   cell_type      out_head_nxt;
   logic          in_full;
   logic          out_full;
   logic          in_found;
   logic          out_found;

   // response register
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;
   logic [HANDLE_W-1:0] handle_ff;
   logic [HANDLE_W-1:0] handle_in;
   logic                nonempty_ff;
   logic                ready_ff;

   logic accept;

   // take a new transaction whenever the response register frees up
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   // operation decode
   always_comb begin
      in_ctl    = '0;
      out_ctl   = '0;
      status_in = ST_OK;
      handle_in = '0;
      case (req_if.op)
         OP_ENQUEUE: begin
            if (in_full) begin
               status_in = ST_FULL;
            end else begin
               in_ctl.push        = accept;
               in_ctl.data_filled = 1'b1;
               in_ctl.data_id     = req_if.event_id;
               in_ctl.data_handle = req_if.event_handle;
            end
         end
         OP_DISPATCH: begin
            if (!in_head.valid) begin
               status_in = ST_EMPTY;
            end else if (sort_mode_ff && out_full) begin
               // incoming entry stays put
               status_in = ST_FULL;
            end else begin
               handle_in  = in_head.handle;
               in_ctl.pop = accept;
               // in sort mode reserve an unfilled slot tagged with the id
               out_ctl.push        = accept && sort_mode_ff;
               out_ctl.data_filled = 1'b0;
               out_ctl.data_id     = in_head.id;
               out_ctl.data_handle = '0;
            end
         end
         OP_COMPLETE: begin
            out_ctl.data_filled = 1'b1;
            out_ctl.data_id     = req_if.event_id;
            out_ctl.data_handle = req_if.event_handle;
            if (sort_mode_ff) begin
               // fill the youngest slot with a matching id
               out_ctl.search = accept;
               if (!out_found) begin
                  status_in = ST_NOTFOUND;
               end
            end else if (out_full) begin
               status_in = ST_FULL;
            end else begin
               out_ctl.push = accept;
            end
         end
         OP_RETIRE: begin
            if (!(out_head.valid && out_head.filled)) begin
               status_in = ST_EMPTY;
            end else begin
               handle_in   = out_head.handle;
               out_ctl.pop = accept;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // the incoming chain never searches, so its found flag stays low
   rorq_chain u_incoming (
      .clock    (clock),
      .reset    (reset),
      .ctl      (in_ctl),
      .head     (in_head),
      .head_nxt (in_head_nxt),
      .full     (in_full),
      .found    (in_found)
   );

   rorq_chain u_outgoing (
      .clock    (clock),
      .reset    (reset),
      .ctl      (out_ctl),
      .head     (out_head),
      .head_nxt (out_head_nxt),
      .full     (out_full),
      .found    (out_found)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_if.ready);

   // response payload, loaded on accept; flags reflect the queues after the op
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         handle_ff   <= handle_in;
         nonempty_ff <= in_head_nxt.valid || in_found;
         ready_ff    <= out_head_nxt.valid && out_head_nxt.filled;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sort_mode_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         // mode only changes while both queues are empty
         if (csr_wr_en && !in_head.valid && !out_head.valid) begin
            sort_mode_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.status            = status_ff;
   assign rsp_if.handle_out        = handle_ff;
   assign rsp_if.incoming_nonempty = nonempty_ff;
   assign rsp_if.outgoing_ready    = ready_ff;

endmodule

`default_nettype wire
